// File: src/line_sensor_pid_steering_defines.svh
// Assertion macros for the line sensor PID steering block.
`ifndef LINE_SENSOR_PID_STEERING_DEFINES_SVH
`define LINE_SENSOR_PID_STEERING_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsps assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsps assertion failed");
`else
`define LSPS_ASSERT_IMP(label, ante, cons)
`define LSPS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: src/lsps_pkg.sv
// Shared constants, codes and control types of the line sensor PID steering block.
`default_nettype none

package lsps_pkg;

  localparam int SENSOR_COUNT = 13;

  localparam int SAMPLE_W   = 10;
  localparam int THR_W      = 10;
  localparam int POS_W      = 12;
  localparam int GAIN_W     = 24;
  localparam int PWM_W      = 8;
  localparam int CLS_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // frame bookkeeping
  localparam int SCNT_W      = $clog2(SENSOR_COUNT);
  localparam int CNT_W       = $clog2(SENSOR_COUNT);
  localparam int MAX_IDX_SUM = (SENSOR_COUNT - 1) * (SENSOR_COUNT - 2) / 2;
  localparam int IDX_W       = $clog2(MAX_IDX_SUM + 1);
  localparam int FRAC_W      = 8;
  localparam int DVD_W       = IDX_W + FRAC_W;

  localparam int WIDE_DARK_COUNT = 10;
  localparam int FORCED_ERROR    = 1536;
  localparam int WIDE_POSITION   = (SENSOR_COUNT * 256 > 4095) ? 4095 : SENSOR_COUNT * 256;

  // PID arithmetic
  localparam int ERR_W       = 16;
  localparam int DERR_W      = ERR_W + 1;
  localparam int INTEG_W     = 32;
  localparam int MUL_A_W     = GAIN_W + 1;
  localparam int PROD_W      = MUL_A_W + INTEG_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int GAIN_FRAC_W = 24;
  localparam int U_W         = ACC_W - GAIN_FRAC_W;
  localparam int DUTY_W      = U_W + 2;
  localparam int MUL_TERMS   = 3;

  // sequencer step counter covers the divider and the multiply sequence
  localparam int STEP_W = $clog2(DVD_W);

  // corner masks
  localparam int EDGE_W = 5;
  localparam logic [SENSOR_COUNT-1:0] ALL_MASK   = {SENSOR_COUNT{1'b1}};
  localparam logic [SENSOR_COUNT-1:0] RIGHT_MASK = SENSOR_COUNT'({EDGE_W{1'b1}});
  localparam logic [SENSOR_COUNT-1:0] LEFT_MASK  = RIGHT_MASK << (SENSOR_COUNT - EDGE_W);

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 3'd5;

  localparam logic [THR_W-1:0]  RST_DARK_THRESHOLD  = 10'd700;
  localparam logic [POS_W-1:0]  RST_CENTER_SETPOINT = 12'd1364;
  localparam logic [GAIN_W-1:0] RST_GAIN_PROP       = 24'd327680;
  localparam logic [GAIN_W-1:0] RST_GAIN_INTEG      = 24'd66;
  localparam logic [GAIN_W-1:0] RST_GAIN_DERIV      = 24'd327680;
  localparam logic [PWM_W-1:0]  RST_BASE_SPEED      = 8'd80;

  typedef enum logic [CLS_W-1:0] {
    CLS_NONE      = 3'd0,
    CLS_LEFT      = 3'd1,
    CLS_RIGHT     = 3'd2,
    CLS_ALL_DARK  = 3'd3,
    CLS_ALL_LIGHT = 3'd4
  } corner_t;

  typedef enum logic [1:0] {
    MSEL_PROP  = 2'd0,
    MSEL_INTEG = 2'd1,
    MSEL_DERIV = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     sample_take;
    logic     div_init;
    logic     div_step;
    logic     err_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     u_load;
    logic     out_load;
  } lsps_cmd_t;

  typedef struct packed {
    logic last_sample;
  } lsps_sts_t;

endpackage

`default_nettype wire

// File: src/lsps_ctrl.sv
// Sequencer of the line sensor PID steering block: frame-end divide, PID and output steps.
`default_nettype none

module lsps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lsps_pkg::lsps_sts_t  sts,
  output lsps_pkg::lsps_cmd_t  cmd
);
  import lsps_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DINIT = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_ERR   = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.sample_take = accept;
        if (accept && sts.last_sample) begin
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == STEP_W'(DVD_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ERR;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_ERR: begin
        cmd.err_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        // one product issued per step, each summed from prod_r into the accumulator
        cmd.mul_en   = (cnt_r < STEP_W'(MUL_TERMS));
        cmd.mul_sel  = mul_sel_t'(cnt_r[1:0]);
        cmd.acc_load = (cnt_r == STEP_W'(1));
        cmd.acc_add  = (cnt_r >= STEP_W'(2));
        if (cnt_r == STEP_W'(MUL_TERMS)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_FIN: begin
        cmd.u_load = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/lsps_dp.sv
// Datapath of the line sensor PID steering block: registers, bit gathering, divider, PID, duties.
`default_nettype none

module lsps_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [lsps_pkg::SAMPLE_W-1:0]      in_sample,
  input  lsps_pkg::lsps_cmd_t                cmd,
  output lsps_pkg::lsps_sts_t                sts,
  output logic                               out_strobe,
  output logic [lsps_pkg::POS_W-1:0]         out_position,
  output logic [lsps_pkg::CLS_W-1:0]         out_corner_class,
  output logic [lsps_pkg::PWM_W-1:0]         out_left_pwm,
  output logic [lsps_pkg::PWM_W-1:0]         out_right_pwm,
  output logic                               out_out_of_range
);
  import lsps_pkg::*;

  function automatic corner_t classify(input logic [SENSOR_COUNT-1:0] bits);
    corner_t c;
    if (bits == '0) begin
      c = CLS_ALL_DARK;
    end else if (bits == ALL_MASK) begin
      c = CLS_ALL_LIGHT;
    end else if ((bits & LEFT_MASK) == LEFT_MASK) begin
      c = CLS_LEFT;
    end else if ((bits & RIGHT_MASK) == RIGHT_MASK) begin
      c = CLS_RIGHT;
    end else begin
      c = CLS_NONE;
    end
    return c;
  endfunction

  // configuration
  logic [THR_W-1:0]  thr_r;
  logic [POS_W-1:0]  setpoint_r;
  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [PWM_W-1:0]  base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= RST_DARK_THRESHOLD;
      setpoint_r <= RST_CENTER_SETPOINT;
      gain_p_r   <= RST_GAIN_PROP;
      gain_i_r   <= RST_GAIN_INTEG;
      gain_d_r   <= RST_GAIN_DERIV;
      base_r     <= RST_BASE_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DARK_THRESHOLD:  thr_r      <= cfg_wdata[THR_W-1:0];
        REG_CENTER_SETPOINT: setpoint_r <= cfg_wdata[POS_W-1:0];
        REG_GAIN_PROP:       gain_p_r   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INTEG:      gain_i_r   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV:      gain_d_r   <= cfg_wdata[GAIN_W-1:0];
        REG_BASE_SPEED:      base_r     <= cfg_wdata[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // sample gathering: light bits plus running dark count and index sum
  logic [SCNT_W-1:0]       scnt_r, scnt_nxt;
  logic [SENSOR_COUNT-1:0] bits_r, bits_nxt;
  logic [CNT_W-1:0]        dark_r, dark_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    light, is_last, first;

  assign light   = (in_sample <= thr_r);
  assign is_last = (scnt_r == SCNT_W'(SENSOR_COUNT - 1));
  assign first   = (scnt_r == '0);
  assign sts.last_sample = is_last;

  always_comb begin
    bits_nxt = first ? '0 : bits_r;
    dark_nxt = first ? '0 : dark_r;
    idx_nxt  = first ? '0 : idx_r;
    if (light) begin
      bits_nxt = bits_nxt | (SENSOR_COUNT'(1) << scnt_r);
    end else if (!is_last) begin
      dark_nxt = dark_nxt + CNT_W'(1);
      idx_nxt  = idx_nxt + IDX_W'(scnt_r);
    end
    scnt_nxt = is_last ? '0 : scnt_r + SCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r <= '0;
      bits_r <= '0;
      dark_r <= '0;
      idx_r  <= '0;
    end else if (cmd.sample_take) begin
      scnt_r <= scnt_nxt;
      bits_r <= bits_nxt;
      dark_r <= dark_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // restoring divider, one quotient bit a step; dividend register becomes the quotient
  logic [DVD_W-1:0] dvd_r;
  logic [CNT_W:0]   rem_r, rem_sh, divisor;
  logic             ge;

  assign rem_sh  = {rem_r[CNT_W-1:0], dvd_r[DVD_W-1]};
  assign divisor = {1'b0, dark_r};
  assign ge      = (rem_sh >= divisor);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_r <= {idx_r, {FRAC_W{1'b0}}};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? (rem_sh - divisor) : rem_sh;
    end
  end

  // error, derivative and saturating integral
  logic                      wide;
  logic [POS_W-1:0]          pos_sel;
  logic signed [ERR_W-1:0]   err;
  logic signed [DERR_W-1:0]  derr;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] isat;

  logic [POS_W-1:0]          pos_r;
  corner_t                   cls_r;
  logic                      wide_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [DERR_W-1:0]  derr_r;
  logic signed [INTEG_W-1:0] integ_r;

  always_comb begin
    wide = (int'(dark_r) >= WIDE_DARK_COUNT);
    if (dark_r == '0) begin
      pos_sel = '0;
    end else if (wide) begin
      pos_sel = POS_W'(WIDE_POSITION);
    end else begin
      pos_sel = dvd_r[POS_W-1:0];
    end
    if (wide) begin
      err = ERR_W'(FORCED_ERROR);
    end else begin
      err = $signed(ERR_W'(setpoint_r)) - $signed(ERR_W'(pos_sel));
    end
    derr = {err[ERR_W-1], err} - {err_r[ERR_W-1], err_r};
    isum = {integ_r[INTEG_W-1], integ_r} + {{(INTEG_W + 1 - ERR_W){err[ERR_W-1]}}, err};
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      isat = isum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}} : {1'b0, {(INTEG_W - 1){1'b1}}};
    end else begin
      isat = isum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r   <= '0;
      integ_r <= '0;
    end else if (cmd.err_load) begin
      err_r   <= err;
      integ_r <= isat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      pos_r  <= pos_sel;
      cls_r  <= classify(bits_r);
      wide_r <= wide;
      derr_r <= derr;
    end
  end

  // shared multiplier and accumulator
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [INTEG_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_adj;
  logic signed [U_W-1:0]     u_r;

  always_comb begin
    case (cmd.mul_sel)
      MSEL_PROP: begin
        mul_a = $signed({1'b0, gain_p_r});
        mul_b = {{(INTEG_W - ERR_W){err_r[ERR_W-1]}}, err_r};
      end
      MSEL_INTEG: begin
        mul_a = $signed({1'b0, gain_i_r});
        mul_b = integ_r;
      end
      MSEL_DERIV: begin
        mul_a = $signed({1'b0, gain_d_r});
        mul_b = {{(INTEG_W - DERR_W){derr_r[DERR_W-1]}}, derr_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // bias negative sums so the shift truncates toward zero
  assign acc_adj = acc_r + (acc_r[ACC_W-1] ? ACC_W'({GAIN_FRAC_W{1'b1}}) : ACC_W'(0));

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.acc_load) begin
      acc_r <= {prod_r[PROD_W-1], prod_r};
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {prod_r[PROD_W-1], prod_r};
    end
    if (cmd.u_load) begin
      u_r <= acc_adj[ACC_W-1:GAIN_FRAC_W];
    end
  end

  // wheel duties and range test
  logic signed [DUTY_W-1:0] base_ext, u_ext, lduty, rduty;
  logic                     l_ok, r_ok;

  assign base_ext = $signed({{(DUTY_W - PWM_W){1'b0}}, base_r});
  assign u_ext    = {{(DUTY_W - U_W){u_r[U_W-1]}}, u_r};
  assign lduty    = base_ext - u_ext;
  assign rduty    = base_ext + u_ext;
  assign l_ok     = (lduty[DUTY_W-1:PWM_W] == '0);
  assign r_ok     = (rduty[DUTY_W-1:PWM_W] == '0);

  logic strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_position     <= pos_r;
      out_corner_class <= cls_r;
      if (cls_r != CLS_NONE) begin
        out_left_pwm     <= '0;
        out_right_pwm    <= '0;
        out_out_of_range <= 1'b0;
      end else if (wide_r || !l_ok || !r_ok) begin
        out_left_pwm     <= '0;
        out_right_pwm    <= '0;
        out_out_of_range <= 1'b1;
      end else begin
        out_left_pwm     <= lduty[PWM_W-1:0];
        out_right_pwm    <= rduty[PWM_W-1:0];
        out_out_of_range <= 1'b0;
      end
    end
  end

  assign out_strobe = strobe_r;

endmodule

`default_nettype wire

// File: src/line_sensor_pid_steering.sv
// Top level of the line sensor centroid and PID steering block.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ------------------------------
//  input    in_sample                               start high, busy low at edge
//  result   out_position .. out_out_of_range        out_strobe, one cycle, no hold
//  config   cfg_index, cfg_wdata                    cfg_we high at edge
//
// A sample that does not close a frame is taken while busy stays low, so samples may
// arrive every cycle. The closing sample raises busy through the bit-serial centroid
// divider, three passes through the shared 25x32 multiplier and the duty stage.
// The result strobes in the first cycle with busy low; a new request may be taken then.
// Synchronous active-low reset restores register defaults and clears frame and PID state.
`default_nettype none
`include "line_sensor_pid_steering_defines.svh"

module line_sensor_pid_steering (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lsps_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            out_strobe,
  output logic [lsps_pkg::POS_W-1:0]      out_position,
  output logic [lsps_pkg::CLS_W-1:0]      out_corner_class,
  output logic [lsps_pkg::PWM_W-1:0]      out_left_pwm,
  output logic [lsps_pkg::PWM_W-1:0]      out_right_pwm,
  output logic                            out_out_of_range,
  input  logic                            cfg_we,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lsps_pkg::*;

  lsps_cmd_t cmd;
  lsps_sts_t sts;

  // sequencer: accepts requests and steps the frame-end work
  lsps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: holds registers, gathers bits, divides, runs PID, drives results
  lsps_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_sample        (in_sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_strobe       (out_strobe),
    .out_position     (out_position),
    .out_corner_class (out_corner_class),
    .out_left_pwm     (out_left_pwm),
    .out_right_pwm    (out_right_pwm),
    .out_out_of_range (out_out_of_range)
  );

  // a result only appears once the sequencer is back to taking requests
  `LSPS_ASSERT_IMP(a_strobe_idle, out_strobe, !busy)
  // busy only rises on a request
  `LSPS_ASSERT_IMP(a_busy_from_start, $rose(busy), $past(start))
  // one strobe per frame, never two in a row
  `LSPS_ASSERT_NXT(a_strobe_pulse, out_strobe, !out_strobe)
  // corners drive both wheels to zero without the range flag
  `LSPS_ASSERT_IMP(a_corner_zero, out_strobe && (out_corner_class != CLS_NONE),
                   (out_left_pwm == '0) && (out_right_pwm == '0) && !out_out_of_range)

endmodule

`default_nettype wire

// File: tb/tb_line_sensor_pid_steering.sv
// Self-checking testbench for the line sensor centroid and PID steering block.
`default_nettype none

module tb_line_sensor_pid_steering;
  import lsps_pkg::*;

  // Allow the longest busy stretch of a frame close, plus margin, before a register write.
  localparam int SETTLE_CYCLES = DVD_W + 9 + 16;
  localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN = -(longint'(1) <<< (INTEG_W - 1));
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int FRAMES_PER_PHASE = 14;

  typedef struct packed {
    logic [POS_W-1:0] position;
    corner_t          corner;
    logic [PWM_W-1:0] left_pwm;
    logic [PWM_W-1:0] right_pwm;
    logic             out_of_range;
  } steer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  out_strobe;
  logic [POS_W-1:0]      out_position;
  logic [CLS_W-1:0]      out_corner_class;
  logic [PWM_W-1:0]      out_left_pwm;
  logic [PWM_W-1:0]      out_right_pwm;
  logic                  out_out_of_range;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  line_sensor_pid_steering dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_sample        (in_sample),
    .out_strobe       (out_strobe),
    .out_position     (out_position),
    .out_corner_class (out_corner_class),
    .out_left_pwm     (out_left_pwm),
    .out_right_pwm    (out_right_pwm),
    .out_out_of_range (out_out_of_range),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Register copies, tracked as they are written.
  logic [THR_W-1:0]  thr_cfg  = RST_DARK_THRESHOLD;
  logic [POS_W-1:0]  setp_cfg = RST_CENTER_SETPOINT;
  logic [GAIN_W-1:0] kp_cfg   = RST_GAIN_PROP;
  logic [GAIN_W-1:0] ki_cfg   = RST_GAIN_INTEG;
  logic [GAIN_W-1:0] kd_cfg   = RST_GAIN_DERIV;
  logic [PWM_W-1:0]  base_cfg = RST_BASE_SPEED;

  // Frame and controller state of the predictor; reset happens once, so start from zero.
  int                     frame_slot = 0;
  logic [SENSOR_COUNT-1:0] light_bits = '0;
  int                     prev_err = 0;
  int                     err_integ = 0;

  logic [SAMPLE_W-1:0] sample_backlog[$];
  steer_t              awaited_steer[$];
  int                  samples_queued = 0;
  int                  samples_taken = 0;
  int                  gap_left = 0;
  int                  idle_odds = 0;
  int                  fails = 0;

  // Fold one accepted sample into the frame; on the closing sample, work out the
  // centroid, run the PID step and queue the steering result it must produce.
  function automatic void track_sample(logic [SAMPLE_W-1:0] s);
    int     dark_n, idx_sum, pos, err, derr;
    longint acc, u, lp, rp, isum;
    bit     wide;
    corner_t cls;
    steer_t r;
    dark_n = 0;
    idx_sum = 0;
    if (frame_slot == 0) light_bits = '0;
    if (s <= thr_cfg) light_bits[frame_slot] = 1'b1;
    frame_slot++;
    if (frame_slot < SENSOR_COUNT) return;
    frame_slot = 0;

    // The top sensor takes part in the corner test only, not the centroid.
    for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
      if (!light_bits[i]) begin
        idx_sum += i;
        dark_n++;
      end
    end
    wide = dark_n >= WIDE_DARK_COUNT;
    if (dark_n == 0) pos = 0;
    else if (wide) pos = WIDE_POSITION;
    else pos = (idx_sum << FRAC_W) / dark_n;

    err = wide ? FORCED_ERROR : int'(setp_cfg) - pos;
    derr = err - prev_err;
    isum = longint'(err_integ) + err;
    if (isum > INTEG_MAX) isum = INTEG_MAX;
    else if (isum < INTEG_MIN) isum = INTEG_MIN;
    err_integ = int'(isum);
    prev_err = err;

    // Q8.16 gains times Q8.8 terms land in Q.24; drop the fraction toward zero.
    acc = longint'(kp_cfg) * err + longint'(ki_cfg) * err_integ + longint'(kd_cfg) * derr;
    u = acc / (longint'(1) <<< GAIN_FRAC_W);

    if (light_bits == '0) cls = CLS_ALL_DARK;
    else if (light_bits == ALL_MASK) cls = CLS_ALL_LIGHT;
    else if ((light_bits & LEFT_MASK) == LEFT_MASK) cls = CLS_LEFT;
    else if ((light_bits & RIGHT_MASK) == RIGHT_MASK) cls = CLS_RIGHT;
    else cls = CLS_NONE;

    r.position = POS_W'(pos);
    r.corner = cls;
    r.left_pwm = '0;
    r.right_pwm = '0;
    r.out_of_range = 1'b0;
    if (cls == CLS_NONE) begin
      lp = longint'(base_cfg) - u;
      rp = longint'(base_cfg) + u;
      if (wide || lp < 0 || lp > 255 || rp < 0 || rp > 255) begin
        r.out_of_range = 1'b1;
      end else begin
        r.left_pwm = PWM_W'(lp);
        r.right_pwm = PWM_W'(rp);
      end
    end
    awaited_steer.push_back(r);
  endfunction

  // Sender: hold each request until the block takes it, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        track_sample(in_sample);
        samples_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (sample_backlog.size() != 0 && idle_odds != 0 &&
                     $urandom_range(1, 100) <= idle_odds) begin
          // This cycle is the first of the burst.
          gap_left = $urandom_range(1, 12) - 1;
          start <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          in_sample <= sample_backlog.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void report(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fails++;
  endfunction

  // Receiver: every strobe must match the oldest outstanding frame result.
  always @(posedge clk) begin : watch
    steer_t want;
    if (rst_n && out_strobe) begin
      if (awaited_steer.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual position %0d",
                 $time, out_position);
        fails++;
      end else begin
        want = awaited_steer.pop_front();
        if (out_position !== want.position)
          report("position", want.position, out_position);
        if (out_corner_class !== want.corner)
          report("corner_class", want.corner, out_corner_class);
        if (out_left_pwm !== want.left_pwm)
          report("left_pwm", want.left_pwm, out_left_pwm);
        if (out_right_pwm !== want.right_pwm)
          report("right_pwm", want.right_pwm, out_right_pwm);
        if (out_out_of_range !== want.out_of_range)
          report("out_of_range", want.out_of_range, out_out_of_range);
      end
    end
  end

  task automatic offer(logic [SAMPLE_W-1:0] s);
    sample_backlog.push_back(s);
    samples_queued++;
  endtask

  // Write one register, with junk above its width that the block must drop.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, int w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(($urandom << w) | val);
    case (idx)
      REG_DARK_THRESHOLD:  thr_cfg  = THR_W'(val);
      REG_CENTER_SETPOINT: setp_cfg = POS_W'(val);
      REG_GAIN_PROP:       kp_cfg   = GAIN_W'(val);
      REG_GAIN_INTEG:      ki_cfg   = GAIN_W'(val);
      REG_GAIN_DERIV:      kd_cfg   = GAIN_W'(val);
      REG_BASE_SPEED:      base_cfg = PWM_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(int thr, int setp, int kp, int ki, int kd, int base);
    write_reg(REG_DARK_THRESHOLD, CFG_DATA_W'(thr), THR_W);
    write_reg(REG_CENTER_SETPOINT, CFG_DATA_W'(setp), POS_W);
    write_reg(REG_GAIN_PROP, CFG_DATA_W'(kp), GAIN_W);
    write_reg(REG_GAIN_INTEG, CFG_DATA_W'(ki), GAIN_W);
    write_reg(REG_GAIN_DERIV, CFG_DATA_W'(kd), GAIN_W);
    write_reg(REG_BASE_SPEED, CFG_DATA_W'(base), PWM_W);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick a light/dark map for one frame, weighted toward frames that reach the duty stage.
  function automatic logic [SENSOR_COUNT-1:0] pick_map();
    logic [SENSOR_COUNT-1:0] m;
    int p, n, run, at;
    case ($urandom_range(0, 9))
      0: begin
        p = $urandom_range(5, 95);
        for (int k = 0; k < SENSOR_COUNT; k++) m[k] = $urandom_range(1, 100) <= p;
      end
      1: m = SENSOR_COUNT'($urandom) | LEFT_MASK;
      2: m = SENSOR_COUNT'($urandom) | RIGHT_MASK;
      3: m = '0;
      4: m = ALL_MASK;
      5: begin
        // Straddle the wide-line threshold on the centroid sensors.
        n = $urandom_range(WIDE_DARK_COUNT - 2, SENSOR_COUNT - 1);
        m = ALL_MASK;
        while (SENSOR_COUNT - 1 - $countones(m[SENSOR_COUNT-2:0]) < n)
          m[$urandom_range(0, SENSOR_COUNT - 2)] = 1'b0;
        m[SENSOR_COUNT-1] = $urandom_range(0, 1);
      end
      default: begin
        // Dark on both edges so no corner is seen, plus a dark run somewhere.
        m = ALL_MASK;
        m[$urandom_range(0, EDGE_W - 1)] = 1'b0;
        m[$urandom_range(SENSOR_COUNT - EDGE_W, SENSOR_COUNT - 1)] = 1'b0;
        run = $urandom_range(0, 6);
        at = $urandom_range(0, SENSOR_COUNT - 1);
        for (int k = 0; k < run; k++) if (at + k < SENSOR_COUNT) m[at + k] = 1'b0;
      end
    endcase
    return m;
  endfunction

  // Queue one frame; light sensors read at or below the threshold, dark ones above it.
  task automatic push_frame(logic [SENSOR_COUNT-1:0] light_map, bit noise);
    int s;
    for (int k = 0; k < SENSOR_COUNT; k++) begin
      if (noise) begin
        s = $urandom_range(0, SAMPLE_MAX);
      end else if (light_map[k] || thr_cfg == THR_W'(SAMPLE_MAX)) begin
        case ($urandom_range(0, 3))
          0: s = 0;
          1: s = thr_cfg;
          default: s = $urandom_range(0, thr_cfg);
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: s = int'(thr_cfg) + 1;
          1: s = SAMPLE_MAX;
          default: s = $urandom_range(int'(thr_cfg) + 1, SAMPLE_MAX);
        endcase
      end
      offer(SAMPLE_W'(s));
    end
  endtask

  task automatic fill_frames(int count);
    for (int f = 0; f < count; f++) begin
      if ($urandom_range(0, 7) == 0) push_frame('0, 1'b1);
      else push_frame(pick_map(), 1'b0);
    end
  endtask

  // Wait until every request is taken and every result is in, then let the block go idle.
  task automatic settle();
    while (samples_taken != samples_queued || awaited_steer.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_gain();
    if ($urandom_range(0, 2) == 0) return int'(GAIN_W'($urandom));
    return $urandom_range(0, 1 << 19);
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: an all-light frame touching the threshold exactly, then an
    // all-dark wide frame just above it, so the frame-start clear is exercised.
    for (int k = 0; k < SENSOR_COUNT; k++) offer(k % 2 ? RST_DARK_THRESHOLD : '0);
    for (int k = 0; k < SENSOR_COUNT; k++)
      offer(k % 2 ? RST_DARK_THRESHOLD + 1'b1 : SAMPLE_W'(SAMPLE_MAX));
    idle_odds = 30;
    fill_frames(10);
    settle();

    for (int ph = 1; ph <= 9; ph++) begin
      case (ph)
        1: set_regs(0, 0, 0, 0, 0, 0);
        2: set_regs(SAMPLE_MAX, WIDE_POSITION, (1 << GAIN_W) - 1, (1 << GAIN_W) - 1,
                    (1 << GAIN_W) - 1, 255);
        3: set_regs($urandom_range(300, 800), RST_CENTER_SETPOINT, $urandom_range(0, 1 << 20),
                    $urandom_range(0, 1000), $urandom_range(0, 1 << 20), 128);
        4: set_regs($urandom_range(0, SAMPLE_MAX), WIDE_POSITION, (1 << GAIN_W) - 1, 0, 0,
                    128);
        5: set_regs(1, 0, RST_GAIN_PROP, RST_GAIN_INTEG, 0, 255);
        9: set_regs(RST_DARK_THRESHOLD, RST_CENTER_SETPOINT, RST_GAIN_PROP, RST_GAIN_INTEG,
                    RST_GAIN_DERIV, RST_BASE_SPEED);
        default: set_regs($urandom_range(0, SAMPLE_MAX), $urandom_range(0, WIDE_POSITION),
                          rand_gain(), rand_gain(), rand_gain(), $urandom_range(0, 255));
      endcase
      // No idling at all in the closing phase.
      case (ph % 3)
        0: idle_odds = 0;
        1: idle_odds = 20;
        default: idle_odds = 60;
      endcase
      if (ph == 9) idle_odds = 0;
      fill_frames(FRAMES_PER_PHASE);
      settle();
    end

    if (fails == 0) begin
      $display("line_sensor_pid_steering regression: pass");
    end else begin
      $display("line_sensor_pid_steering regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake or a missing result.
  initial begin
    #3000000;
    $display("line_sensor_pid_steering regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
